// ----- src/boc_pkg.sv -----
// Shared types and constants for the bytecode opcode unpacker.
package boc_pkg;

  localparam int unsigned WORD_COUNT_BITS = 24;
  localparam int unsigned CNT_BITS        = WORD_COUNT_BITS + 1;
  localparam int unsigned OPCODE_BITS     = 6;
  localparam int unsigned ARG_BITS        = 32;
  localparam int unsigned BYTE_BITS       = 8;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned QPTR_BITS       = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_BITS       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    FORM_SHORT = 2'd0,
    FORM_BIT   = 2'd1,
    FORM_BYTE  = 2'd2,
    FORM_WORD  = 2'd3
  } form_e;

  typedef struct packed {
    logic [OPCODE_BITS-1:0] opcode;
    logic [ARG_BITS-1:0]    argument;
    logic                   has_arg;
  } op_t;

endpackage

// ----- src/boc_front.sv -----
// Front end: accepts packed bytes and assembles complete instructions.
module boc_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          restart_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [7:0]    in_byte_i,
  input  logic          full_i,
  output logic          push_o,
  output boc_pkg::op_t  op_o
);
  import boc_pkg::*;

  typedef enum logic [2:0] {
    PH_LEAD = 3'd0,
    PH_BYTE = 3'd1,
    PH_W0   = 3'd2,
    PH_W1   = 3'd3,
    PH_W2   = 3'd4,
    PH_W3   = 3'd5
  } phase_e;

  phase_e                 phase_q, phase_d;
  logic [OPCODE_BITS-1:0] opcode_q, opcode_d;
  logic [ARG_BITS-1:0]    arg_q, arg_d;
  logic                   accept;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;

  always_comb begin
    phase_d  = phase_q;
    opcode_d = opcode_q;
    arg_d    = arg_q;
    push_o   = 1'b0;
    op_o     = '0;
    if (accept) begin
      case (phase_q)
        PH_LEAD: begin
          case (form_e'(in_byte_i[1:0]))
            FORM_SHORT: begin
              push_o      = 1'b1;
              op_o.opcode = in_byte_i[7:2];
            end
            FORM_BIT: begin
              push_o        = 1'b1;
              op_o.opcode   = {1'b0, in_byte_i[7:3]};
              op_o.argument = {{(ARG_BITS-1){1'b0}}, in_byte_i[2]};
              op_o.has_arg  = 1'b1;
            end
            FORM_BYTE: begin
              opcode_d = in_byte_i[7:2];
              arg_d    = '0;
              phase_d  = PH_BYTE;
            end
            FORM_WORD: begin
              opcode_d = in_byte_i[7:2];
              arg_d    = '0;
              phase_d  = PH_W0;
            end
            default: phase_d = PH_LEAD;
          endcase
        end
        PH_BYTE: begin
          push_o        = 1'b1;
          op_o.opcode   = opcode_q;
          op_o.argument = {{(ARG_BITS-BYTE_BITS){1'b0}}, in_byte_i};
          op_o.has_arg  = 1'b1;
          phase_d       = PH_LEAD;
        end
        PH_W0: begin
          arg_d[7:0] = in_byte_i;
          phase_d    = PH_W1;
        end
        PH_W1: begin
          arg_d[15:8] = in_byte_i;
          phase_d     = PH_W2;
        end
        PH_W2: begin
          arg_d[23:16] = in_byte_i;
          phase_d      = PH_W3;
        end
        PH_W3: begin
          push_o        = 1'b1;
          op_o.opcode   = opcode_q;
          op_o.argument = {in_byte_i, arg_q[23:0]};
          op_o.has_arg  = 1'b1;
          phase_d       = PH_LEAD;
        end
        default: phase_d = PH_LEAD;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_LEAD;
      opcode_q <= '0;
      arg_q    <= '0;
    end else if (restart_i) begin
      phase_q  <= PH_LEAD;
      opcode_q <= '0;
      arg_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      opcode_q <= opcode_d;
      arg_q    <= arg_d;
    end
  end

endmodule

// ----- src/boc_queue.sv -----
// Short queue of assembled instructions between front end and back end.
module boc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          restart_i,
  input  logic          push_i,
  input  boc_pkg::op_t  op_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          pop_i,
  output boc_pkg::op_t  op_o
);
  import boc_pkg::*;

  op_t                  mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_BITS-1:0] cnt_q;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_BITS'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign op_o    = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else if (restart_i) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ----- src/boc_back.sv -----
// Back end: counts unpacked words, flags completion and overrun, holds the result.
module boc_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                restart_i,
  input  logic [boc_pkg::WORD_COUNT_BITS-1:0] code_words_i,
  input  logic                                q_valid_i,
  input  boc_pkg::op_t                        q_op_i,
  output logic                                q_pop_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [boc_pkg::OPCODE_BITS-1:0]     opcode_o,
  output logic signed [boc_pkg::ARG_BITS-1:0] argument_o,
  output logic                                has_argument_o,
  output logic [boc_pkg::WORD_COUNT_BITS-1:0] word_index_o,
  output logic                                last_op_o,
  output logic                                overrun_o
);
  import boc_pkg::*;

  logic [CNT_BITS-1:0]    count_q, count_d;
  logic                   finished_q, finished_d;
  logic                   valid_q, valid_d;
  logic [OPCODE_BITS-1:0] opcode_q;
  logic [ARG_BITS-1:0]    arg_q;
  logic                   has_arg_q, last_q, over_q;
  logic [WORD_COUNT_BITS-1:0] index_q;

  logic [CNT_BITS-1:0]    cw_ext, next_count;
  logic [CNT_BITS:0]      arg_pos;
  logic                   at_end, emit, last, over;

  assign cw_ext     = {1'b0, code_words_i};
  assign at_end     = finished_q || (count_q >= cw_ext);
  assign q_pop_o    = q_valid_i && (!valid_q || !out_stall_i);
  assign emit       = q_pop_o && !at_end;
  assign next_count = count_q + (q_op_i.has_arg ? CNT_BITS'(2) : CNT_BITS'(1));
  assign arg_pos    = {1'b0, count_q} + (CNT_BITS+1)'(1);
  assign last       = next_count >= cw_ext;
  assign over       = q_op_i.has_arg && (arg_pos >= {1'b0, cw_ext});

  always_comb begin
    count_d    = count_q;
    finished_d = finished_q;
    valid_d    = valid_q && out_stall_i;
    if (q_pop_o) begin
      if (at_end) begin
        finished_d = 1'b1;
      end else begin
        count_d    = next_count;
        finished_d = last;
        valid_d    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      finished_q <= 1'b0;
      valid_q    <= 1'b0;
    end else if (restart_i) begin
      count_q    <= '0;
      finished_q <= 1'b0;
      valid_q    <= 1'b0;
    end else begin
      count_q    <= count_d;
      finished_q <= finished_d;
      valid_q    <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      opcode_q  <= q_op_i.opcode;
      arg_q     <= q_op_i.argument;
      has_arg_q <= q_op_i.has_arg;
      index_q   <= count_q[WORD_COUNT_BITS-1:0];
      last_q    <= last;
      over_q    <= over;
    end
  end

  assign out_valid_o    = valid_q;
  assign opcode_o       = opcode_q;
  assign argument_o     = $signed(arg_q);
  assign has_argument_o = has_arg_q;
  assign word_index_o   = index_q;
  assign last_op_o      = last_q;
  assign overrun_o      = over_q;

endmodule

// ----- src/bytecode_opcode_unpacker_unit.sv -----
// Bytecode opcode unpacker: one packed byte in per cycle unless stalled; one instruction out
// when complete. Bytes stall only while the queue is full; an instruction's final byte
// writes it into the queue, and the output register loads it from there when not stalled.
// A two-entry queue separates byte assembly from word counting, so input keeps flowing for
// two instructions while the output is stalled. Writing code_words restarts the unit; once
// the op that reaches the code size has been delivered, later bytes are taken and discarded
// until the next write.
module bytecode_opcode_unpacker_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [boc_pkg::WORD_COUNT_BITS-1:0] cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [7:0]                          in_byte_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [boc_pkg::OPCODE_BITS-1:0]     opcode_o,
  output logic signed [boc_pkg::ARG_BITS-1:0] argument_o,
  output logic                                has_argument_o,
  output logic [boc_pkg::WORD_COUNT_BITS-1:0] word_index_o,
  output logic                                last_op_o,
  output logic                                overrun_o
);
  import boc_pkg::*;

  logic [WORD_COUNT_BITS-1:0] code_words_q;
  logic                       push, full, q_valid, q_pop;
  op_t                        push_op, q_op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_words_q <= '0;
    end else if (cfg_we_i) begin
      code_words_q <= cfg_data_i;
    end
  end

  boc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .restart_i  (cfg_we_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .full_i     (full),
    .push_o     (push),
    .op_o       (push_op)
  );

  boc_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (cfg_we_i),
    .push_i    (push),
    .op_i      (push_op),
    .full_o    (full),
    .valid_o   (q_valid),
    .pop_i     (q_pop),
    .op_o      (q_op)
  );

  boc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .restart_i      (cfg_we_i),
    .code_words_i   (code_words_q),
    .q_valid_i      (q_valid),
    .q_op_i         (q_op),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .opcode_o       (opcode_o),
    .argument_o     (argument_o),
    .has_argument_o (has_argument_o),
    .word_index_o   (word_index_o),
    .last_op_o      (last_op_o),
    .overrun_o      (overrun_o)
  );

endmodule

// ----- src/boc_checker.sv -----
// Port-level checks for the bytecode opcode unpacker, bound to the top level.
module boc_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic                                out_valid_o,
  input  logic                                out_stall_i,
  input  logic [boc_pkg::OPCODE_BITS-1:0]     opcode_o,
  input  logic signed [boc_pkg::ARG_BITS-1:0] argument_o,
  input  logic                                has_argument_o,
  input  logic [boc_pkg::WORD_COUNT_BITS-1:0] word_index_o,
  input  logic                                last_op_o,
  input  logic                                overrun_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i && !cfg_we_i |=>
      out_valid_o && $stable(opcode_o) && $stable(argument_o) && $stable(word_index_o))
    else $error("stalled transaction changed");

  a_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && last_op_o && !cfg_we_i |=> !out_valid_o)
    else $error("transaction after last op");

  a_over_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !overrun_o || last_op_o)
    else $error("overrun without last op");

  a_no_arg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_argument_o |-> argument_o == 0 && !overrun_o)
    else $error("argument set on op without argument");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !out_valid_o)
    else $error("output valid after restart");

endmodule

bind bytecode_opcode_unpacker_unit boc_checker u_boc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .cfg_we_i       (cfg_we_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .opcode_o       (opcode_o),
  .argument_o     (argument_o),
  .has_argument_o (has_argument_o),
  .word_index_o   (word_index_o),
  .last_op_o      (last_op_o),
  .overrun_o      (overrun_o)
);

// ----- tb/sv/tb_bytecode_opcode_unpacker_unit.sv -----
// Self-checking testbench for the bytecode opcode unpacker: directed and random byte streams.
module tb_bytecode_opcode_unpacker_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import boc_pkg::*;

  localparam int SETTLE_CYCLES  = 8;
  localparam int CHOKE_CYCLES   = 120;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BYTES   = 550;

  typedef enum logic [2:0] {
    PH_LEAD = 3'd0,
    PH_BYTE = 3'd1,
    PH_ARG0 = 3'd2,
    PH_ARG1 = 3'd3,
    PH_ARG2 = 3'd4,
    PH_ARG3 = 3'd5
  } unpack_phase_e;

  typedef struct packed {
    logic [OPCODE_BITS-1:0]     opcode;
    logic [ARG_BITS-1:0]        argument;
    logic                       has_arg;
    logic [WORD_COUNT_BITS-1:0] word_index;
    logic                       last_op;
    logic                       overrun;
  } unpacked_op_t;

  typedef struct {
    logic                   raw;
    form_e                  form;
    logic [OPCODE_BITS-1:0] op;
    logic [ARG_BITS-1:0]    arg;
  } instr_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we = 1'b0;
  logic [WORD_COUNT_BITS-1:0] cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [7:0]                 in_byte = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [OPCODE_BITS-1:0]     opcode;
  logic signed [ARG_BITS-1:0] argument;
  logic                       has_argument;
  logic [WORD_COUNT_BITS-1:0] word_index;
  logic                       last_op;
  logic                       overrun;

  logic [7:0]   code_stream_q[$];
  unpacked_op_t unpacked_q[$];

  logic [WORD_COUNT_BITS-1:0] code_words = '0;
  unpack_phase_e              up_phase = PH_LEAD;
  logic [OPCODE_BITS-1:0]     held_opcode = '0;
  logic [ARG_BITS-1:0]        arg_acc = '0;
  logic [CNT_BITS-1:0]        words_done = '0;
  logic                       code_done = 1'b0;
  int                         bytes_used = 0;

  int snd_max = 0;
  int rcv_max = 0;
  int send_gap = 0;
  int rcv_wait = 0;
  int hold_left = 0;
  int choke_req = 0;
  int choke_ack = 0;
  int quiet = 0;
  int err_cnt = 0;

  bytecode_opcode_unpacker_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .in_byte_i      (in_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .opcode_o       (opcode),
    .argument_o     (argument),
    .has_argument_o (has_argument),
    .word_index_o   (word_index),
    .last_op_o      (last_op),
    .overrun_o      (overrun)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic restart_unpack();
    up_phase    = PH_LEAD;
    held_opcode = '0;
    arg_acc     = '0;
    words_done  = '0;
    code_done   = 1'b0;
  endtask

  function automatic void add_byte(input logic [7:0] b);
    code_stream_q.insert(code_stream_q.size(), b);
  endfunction

  task automatic finish_instr(input logic [OPCODE_BITS-1:0] op, input logic [ARG_BITS-1:0] arg,
                              input logic has_arg);
    unpacked_op_t        e;
    logic [CNT_BITS-1:0] nxt;
    nxt          = CNT_BITS'(words_done + (has_arg ? 2 : 1));
    e.opcode     = op;
    e.argument   = arg;
    e.has_arg    = has_arg;
    e.word_index = words_done[WORD_COUNT_BITS-1:0];
    e.last_op    = nxt >= CNT_BITS'(code_words);
    e.overrun    = has_arg && ((32'(words_done) + 32'd1) >= 32'(code_words));
    unpacked_q.insert(unpacked_q.size(), e);
    words_done = nxt;
    if (e.last_op) code_done = 1'b1;
    up_phase    = PH_LEAD;
    held_opcode = '0;
    arg_acc     = '0;
  endtask

  task automatic unpack_byte(input logic [7:0] b);
    bytes_used++;
    if (!code_done) begin
      case (up_phase)
        PH_LEAD: begin
          if (words_done >= CNT_BITS'(code_words)) begin
            code_done = 1'b1;
          end else begin
            case (form_e'(b[1:0]))
              FORM_SHORT: finish_instr(b[7:2], '0, 1'b0);
              FORM_BIT:   finish_instr({1'b0, b[7:3]}, ARG_BITS'(b[2]), 1'b1);
              FORM_BYTE: begin
                held_opcode = b[7:2];
                arg_acc     = '0;
                up_phase    = PH_BYTE;
              end
              default: begin
                held_opcode = b[7:2];
                arg_acc     = '0;
                up_phase    = PH_ARG0;
              end
            endcase
          end
        end
        PH_BYTE: finish_instr(held_opcode, ARG_BITS'(b), 1'b1);
        PH_ARG0: begin
          arg_acc[7:0] = b;
          up_phase     = PH_ARG1;
        end
        PH_ARG1: begin
          arg_acc[15:8] = b;
          up_phase      = PH_ARG2;
        end
        PH_ARG2: begin
          arg_acc[23:16] = b;
          up_phase       = PH_ARG3;
        end
        PH_ARG3: finish_instr(held_opcode, {b, arg_acc[23:0]}, 1'b1);
        default: up_phase = PH_LEAD;
      endcase
    end
  endtask

  function automatic void field_ok(input string name, input logic [ARG_BITS-1:0] want,
                                   input logic [ARG_BITS-1:0] got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  task automatic queue_instr(input instr_t it);
    if (it.raw) begin
      add_byte(it.arg[7:0]);
    end else begin
      case (it.form)
        FORM_SHORT: add_byte({it.op, FORM_SHORT});
        FORM_BIT:   add_byte({it.op[4:0], it.arg[0], FORM_BIT});
        FORM_BYTE: begin
          add_byte({it.op, FORM_BYTE});
          add_byte(it.arg[7:0]);
        end
        default: begin
          add_byte({it.op, FORM_WORD});
          for (int i = 0; i < 4; i++) add_byte(it.arg[8*i +: 8]);
        end
      endcase
    end
  endtask

  function automatic instr_t mk_instr(input form_e f, input logic [OPCODE_BITS-1:0] op,
                                      input logic [ARG_BITS-1:0] arg);
    instr_t it;
    it.raw  = 1'b0;
    it.form = f;
    it.op   = op;
    it.arg  = arg;
    return it;
  endfunction

  task automatic settle();
    while (code_stream_q.size() != 0 || in_valid || unpacked_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_code_size(input logic [WORD_COUNT_BITS-1:0] v);
    settle();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // sender: feed the code stream, hold a stalled byte, draw a gap per byte
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      in_byte    <= '0;
      send_gap   <= 0;
      code_words = '0;
      restart_unpack();
    end else begin
      if (cfg_we) begin
        code_words = cfg_data;
        restart_unpack();
      end
      if (in_valid && !in_stall) unpack_byte(in_byte);
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (code_stream_q.size() != 0) begin
          in_valid <= 1'b1;
          in_byte  <= code_stream_q.pop_front();
          send_gap <= $urandom_range(0, snd_max);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: check each transaction, then stall for a randomly drawn wait or a choke
  always @(posedge clk_i or negedge rst_ni) begin
    unpacked_op_t want;
    int           nw;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      rcv_wait  <= 0;
      hold_left <= 0;
      choke_ack <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (unpacked_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result, expected none, actual opcode %0h word %0h",
                   $time, opcode, word_index);
        end else begin
          want = unpacked_q.pop_front();
          field_ok("opcode", ARG_BITS'(want.opcode), ARG_BITS'(opcode));
          field_ok("argument", want.argument, argument);
          field_ok("has_argument", ARG_BITS'(want.has_arg), ARG_BITS'(has_argument));
          field_ok("word_index", ARG_BITS'(want.word_index), ARG_BITS'(word_index));
          field_ok("last_op", ARG_BITS'(want.last_op), ARG_BITS'(last_op));
          field_ok("overrun", ARG_BITS'(want.overrun), ARG_BITS'(overrun));
        end
      end
      if (choke_req != choke_ack) begin
        choke_ack <= choke_req;
        hold_left <= CHOKE_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (out_valid && !out_stall) begin
        nw = $urandom_range(0, rcv_max);
        out_stall <= (nw != 0);
        rcv_wait  <= (nw != 0) ? nw - 1 : 0;
      end else if (rcv_wait != 0) begin
        rcv_wait  <= rcv_wait - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : stimulus
    instr_t                     batch[$];
    instr_t                     it;
    int                         n;
    int                         words;
    int                         d;
    logic [WORD_COUNT_BITS-1:0] cw;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero code size after reset: nothing unpacks
    add_byte(8'hFF);
    add_byte(8'h00);

    load_code_size(24'd40);
    queue_instr(mk_instr(FORM_SHORT, 6'd0, '0));
    queue_instr(mk_instr(FORM_SHORT, 6'd63, '0));
    queue_instr(mk_instr(FORM_BIT, 6'd0, 32'd0));
    queue_instr(mk_instr(FORM_BIT, 6'd31, 32'd1));
    queue_instr(mk_instr(FORM_BYTE, 6'd63, 32'hFF));
    queue_instr(mk_instr(FORM_BYTE, 6'd0, 32'h00));
    queue_instr(mk_instr(FORM_WORD, 6'd42, 32'h8000_0000));
    queue_instr(mk_instr(FORM_WORD, 6'd21, 32'h7FFF_FFFF));

    // exact completion, then a byte after the code is complete
    load_code_size(24'd3);
    queue_instr(mk_instr(FORM_SHORT, 6'd5, '0));
    queue_instr(mk_instr(FORM_BYTE, 6'd9, 32'h5A));
    add_byte(8'h03);

    // argument word past the code size
    load_code_size(24'd1);
    queue_instr(mk_instr(FORM_BIT, 6'd17, 32'd1));

    // truncated stream, restarted by the next write
    load_code_size(24'hFF_FFFF);
    add_byte({6'd33, FORM_WORD});
    add_byte(8'hA5);
    add_byte(8'h5A);

    // receiver chokes while the sender runs at full rate
    load_code_size(24'hFF_FFFF);
    snd_max = 0;
    rcv_max = 0;
    choke_req++;
    for (int i = 0; i < 40; i++) begin
      queue_instr(mk_instr(($urandom_range(0, 1) != 0) ? FORM_SHORT : FORM_BIT,
                           6'($urandom), 32'($urandom)));
    end

    while (bytes_used + code_stream_q.size() < RANDOM_BYTES) begin
      batch.delete();
      words = 0;
      n = $urandom_range(1, 20);
      for (int i = 0; i < n; i++) begin
        it = mk_instr(form_e'($urandom_range(0, 3)), 6'($urandom), 32'($urandom));
        case ($urandom_range(0, 7))
          0: it.arg = 32'h8000_0000;
          1: it.arg = 32'h7FFF_FFFF;
          2: it.arg = 32'hFFFF_FFFF;
          3: it.arg = 32'h0;
          default: ;
        endcase
        it.raw = ($urandom_range(0, 9) == 0);
        if (!it.raw) words += (it.form == FORM_SHORT) ? 1 : 2;
        batch.insert(batch.size(), it);
      end
      case ($urandom_range(0, 9))
        0: cw = '0;
        1: cw = 24'hFF_FFFF;
        2, 3, 4: cw = WORD_COUNT_BITS'(words);
        5, 6: begin
          d  = $urandom_range(1, 3);
          cw = (words > d) ? WORD_COUNT_BITS'(words - d) : 24'd1;
        end
        7, 8: cw = WORD_COUNT_BITS'(words + $urandom_range(1, 3));
        default: cw = WORD_COUNT_BITS'($urandom);
      endcase
      load_code_size(cw);
      case ($urandom_range(0, 3))
        0: snd_max = 0;
        1: snd_max = 2;
        default: snd_max = 8;
      endcase
      case ($urandom_range(0, 3))
        0: rcv_max = 0;
        1: rcv_max = 2;
        default: rcv_max = 8;
      endcase
      if ($urandom_range(0, 11) == 0) choke_req++;
      foreach (batch[i]) queue_instr(batch[i]);
      if ($urandom_range(0, 5) == 0) begin
        add_byte({6'($urandom), ($urandom_range(0, 1) != 0) ? FORM_WORD : FORM_BYTE});
        repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
      end
    end

    settle();
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/boc_pkg.sv
src/boc_front.sv
src/boc_queue.sv
src/boc_back.sv
src/bytecode_opcode_unpacker_unit.sv
src/boc_checker.sv
tb/sv/tb_bytecode_opcode_unpacker_unit.sv
